### sv/tsm_pkg.sv
`default_nettype none

package tsm_pkg;

    localparam int SLOT_DEPTH = 8;
    localparam int DATA_WIDTH = 32;
    localparam int NUM_STACKS = 3;
    localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);

    // operation codes
    localparam logic [2:0] FN_PUSH    = 3'd0;
    localparam logic [2:0] FN_POP     = 3'd1;
    localparam logic [2:0] FN_QEMPTY  = 3'd2;
    localparam logic [2:0] FN_QFULL   = 3'd3;
    localparam logic [2:0] FN_DISPLAY = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_BADSTK = 3'd3;
    localparam logic [2:0] ST_BADOP  = 3'd4;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [1:0]            t_sel;

    // shift command shared by every cell of the chain
    typedef struct packed {
        logic en;   // move the selected stack this cycle
        logic up;   // 1: towards cell 0 (pop, rotate); 0: away from it (push)
        t_sel sel;  // stack being moved, 0..2
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/three_stacks_in_one_memory.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------------
// request  | in        | i_in_valid / o_in_stall   | i_func, i_stack_id, i_push_data
// result   | out       | o_out_valid / i_out_stall | o_status, o_data_out, o_is_empty,
//          |           |                           | o_is_full, o_last
//
// Push, pop, queries and errors give one result transaction each.
// Display of a stack holding n words rotates it through the cell chain, one word
// per cycle unless the result side stalls; n result transactions follow the request.
// A request is taken only while no display runs and the result register is free
// or being emptied; a stall on the result side holds the whole block.
// Reset (synchronous, active low) empties all three stacks; stored words are kept.
`default_nettype none

module three_stacks_in_one_memory
    import tsm_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire  [2:0]        i_func,
    input  wire  [1:0]        i_stack_id,
    input  wire signed [31:0] i_push_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [2:0]        o_status,
    output logic signed [31:0] o_data_out,
    output logic              o_is_empty,
    output logic              o_is_full,
    output logic              o_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    // Control state
    logic       r_state, n_state;
    t_cnt       r_occ [NUM_STACKS];
    t_sel       r_dsel, n_dsel;   // stack being displayed
    t_cnt       r_dcnt, n_dcnt;   // its word count
    t_cnt       r_idx,  n_idx;    // words emitted so far
    logic       r_ovalid, n_ovalid;

    // Result register (payload, no reset)
    logic [2:0] r_status, n_status;
    t_word      r_data,   n_data;
    logic       r_empty,  n_empty;
    logic       r_full,   n_full;
    logic       r_last,   n_last;

    // Occupancy write-back
    logic       occ_we;
    t_cnt       occ_new;

    t_cell_ctl  cell_ctl;
    t_word      cell_word [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0] wrap;

    logic       out_free;
    logic       accept;
    t_sel       in_sel;
    t_cnt       in_cnt;
    t_word      push_word;

    assign out_free  = !r_ovalid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign accept    = i_in_valid && !o_in_stall;
    assign in_sel    = i_stack_id - 2'd1;
    assign push_word = DATA_WIDTH'($unsigned(i_push_data));

    // Look up the count of the addressed stack; stack 0 never gets that far
    always_comb begin
        case (i_stack_id)
            2'd1:    in_cnt = r_occ[0];
            2'd2:    in_cnt = r_occ[1];
            2'd3:    in_cnt = r_occ[2];
            default: in_cnt = '0;
        endcase
    end

    // The chain: cell 0 holds the top of every stack. A push moves the selected
    // stack one cell down, a pop one cell up. Display rotates upwards, the head
    // wrapping into the cell of the oldest word, so after n steps the stack is
    // back as it was.
    for (genvar k = 0; k < SLOT_DEPTH; k++) begin : g_cell
        t_word below, above;

        assign wrap[k] = (r_state == S_DISP) && (t_cnt'(k) == r_dcnt - t_cnt'(1));

        if (k == 0) begin : g_first
            assign below = push_word;
        end else begin : g_mid
            assign below = cell_word[k-1];
        end

        if (k == SLOT_DEPTH - 1) begin : g_last
            assign above = cell_word[k];
        end else begin : g_inner
            assign above = cell_word[k+1];
        end

        tsm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_wrap  (wrap[k]),
            .i_below (below),
            .i_above (above),
            .i_head  (cell_word[0]),
            .o_word  (cell_word[k])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_dsel   = r_dsel;
        n_dcnt   = r_dcnt;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && i_out_stall;
        n_status = r_status;
        n_data   = r_data;
        n_empty  = r_empty;
        n_full   = r_full;
        n_last   = r_last;
        occ_we   = 1'b0;
        occ_new  = in_cnt;
        cell_ctl = '{en: 1'b0, up: 1'b0, sel: in_sel};

        if (accept) begin
            // Default: a single, final result with everything clear
            n_ovalid = 1'b1;
            n_status = ST_OK;
            n_data   = '0;
            n_empty  = 1'b0;
            n_full   = 1'b0;
            n_last   = 1'b1;

            if (!(i_func inside {FN_PUSH, FN_POP, FN_QEMPTY, FN_QFULL, FN_DISPLAY})) begin
                n_status = ST_BADOP;
            end else if (i_stack_id == 2'd0) begin
                n_status = ST_BADSTK;
            end else begin
                case (i_func)
                    FN_PUSH: begin
                        if (in_cnt == t_cnt'(SLOT_DEPTH)) begin
                            n_status = ST_FULL;
                            n_full   = 1'b1;
                        end else begin
                            cell_ctl.en = 1'b1;
                            occ_we      = 1'b1;
                            occ_new     = in_cnt + t_cnt'(1);
                            n_full      = (occ_new == t_cnt'(SLOT_DEPTH));
                        end
                    end
                    FN_POP: begin
                        if (in_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_empty  = 1'b1;
                        end else begin
                            // top word leaves through cell 0 as the stack moves up
                            n_data      = cell_word[0];
                            cell_ctl.en = 1'b1;
                            cell_ctl.up = 1'b1;
                            occ_we      = 1'b1;
                            occ_new     = in_cnt - t_cnt'(1);
                            n_empty     = (occ_new == '0);
                        end
                    end
                    FN_DISPLAY: begin
                        if (in_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_empty  = 1'b1;
                        end else begin
                            // hand over to the rotation; no result this cycle
                            n_ovalid = 1'b0;
                            n_state  = S_DISP;
                            n_dsel   = in_sel;
                            n_dcnt   = in_cnt;
                            n_idx    = '0;
                        end
                    end
                    default: begin
                        // both queries: flags only
                        n_empty = (in_cnt == '0);
                        n_full  = (in_cnt == t_cnt'(SLOT_DEPTH));
                    end
                endcase
            end
        end else if (r_state == S_DISP && out_free) begin
            // Emit the head, rotate one step
            cell_ctl = '{en: 1'b1, up: 1'b1, sel: r_dsel};
            n_ovalid = 1'b1;
            n_status = ST_OK;
            n_data   = cell_word[0];
            n_empty  = 1'b0;
            n_full   = (r_dcnt == t_cnt'(SLOT_DEPTH));
            n_last   = (r_idx == r_dcnt - t_cnt'(1));
            n_idx    = r_idx + t_cnt'(1);
            if (n_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dsel   <= '0;
            r_dcnt   <= '0;
            r_idx    <= '0;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_occ[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_dsel   <= n_dsel;
            r_dcnt   <= n_dcnt;
            r_idx    <= n_idx;
            if (occ_we) begin
                r_occ[in_sel] <= occ_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_empty  <= n_empty;
        r_full   <= n_full;
        r_last   <= n_last;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_status;
    assign o_data_out  = 32'($unsigned(r_data));
    assign o_is_empty  = r_empty;
    assign o_is_full   = r_full;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### sv/tsm_cell.sv
`default_nettype none

module tsm_cell
    import tsm_pkg::*;
(
    input  wire        i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire        i_wrap,   // take the head word instead of the upper neighbour
    input  wire t_word i_below,  // neighbour nearer the top of stack (or push data)
    input  wire t_word i_above,  // neighbour further from the top of stack
    input  wire t_word i_head,   // word of cell 0, for rotation
    output t_word      o_word
);

    t_word r_word [NUM_STACKS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.up) begin
                r_word[i_ctl.sel] <= i_wrap ? i_head : i_above;
            end else begin
                r_word[i_ctl.sel] <= i_below;
            end
        end
    end

    assign o_word = r_word[i_ctl.sel];

endmodule

`default_nettype wire

### bench/three_stacks_in_one_memory_test.sv
`timescale 1ns / 1ps

module three_stacks_in_one_memory_test
    import tsm_pkg::*;
();

    // Operation codes the block must refuse, and the stack id it must refuse
    localparam logic [2:0] FN_BAD_LO  = 3'd5;
    localparam logic [2:0] FN_BAD_MID = 3'd6;
    localparam logic [2:0] FN_BAD_HI  = 3'd7;
    localparam logic [1:0] SID_NONE   = 2'd0;

    localparam int RANDOM_REQUESTS = 155;
    localparam int MAX_WAIT        = 12;
    localparam int HOLD_AT         = 70;   // requests taken before the long receiver hold-off
    localparam int HOLD_CYCLES     = 150;
    localparam int CALM_FROM       = 140;  // window of requests with no idling on either side
    localparam int CALM_TO         = 170;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 3 * SLOT_DEPTH + 16;
    localparam int REPORT_CAP      = 100;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  sid;
        logic [31:0] word;
        logic        drain;  // hold this request back until every reply has arrived
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data;
        logic        empty;
        logic        full;
        logic        tail;
    } t_reply;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [2:0]         i_func      = '0;
    logic [1:0]         i_stack_id  = '0;
    logic signed [31:0] i_push_data = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_status;
    logic signed [31:0] o_data_out;
    logic               o_is_empty;
    logic               o_is_full;
    logic               o_last;

    three_stacks_in_one_memory DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_stack_id  (i_stack_id),
        .i_push_data (i_push_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the three stacks
    t_word       stack_mem  [NUM_STACKS][SLOT_DEPTH];
    int unsigned stack_fill [NUM_STACKS];

    t_request    requests_pending[$];
    t_reply      replies_due[$];
    t_request    active_req;

    int unsigned requests_taken = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_wait      = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned idle_cycles    = 0;
    int unsigned failures       = 0;
    bit          send_fire;
    bit          send_offer;
    bit          reply_taken;

    // ------------------------------------------------------------------
    // Expected replies
    // ------------------------------------------------------------------

    function automatic t_reply make_reply(logic [2:0] st, logic [31:0] d, bit emp, bit ful,
                                          bit fin);
        t_reply r;
        r.status = st;
        r.data   = d;
        r.empty  = emp;
        r.full   = ful;
        r.tail   = fin;
        return r;
    endfunction

    // Apply one request to the shadow stacks and queue the replies it should cause
    task automatic predict_replies(input t_request rq);
        int          s;
        int unsigned n;
        int unsigned i;
        logic [2:0]  st;
        logic [31:0] d;
        st = ST_OK;
        d  = '0;
        // the operation check wins over the stack check
        if (rq.func > FN_DISPLAY) begin
            replies_due.push_back(make_reply(ST_BADOP, '0, 1'b0, 1'b0, 1'b1));
            return;
        end
        if (rq.sid == SID_NONE) begin
            replies_due.push_back(make_reply(ST_BADSTK, '0, 1'b0, 1'b0, 1'b1));
            return;
        end
        s = rq.sid - 1;
        n = stack_fill[s];
        case (rq.func)
            FN_PUSH: begin
                if (n == SLOT_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    stack_mem[s][n] = t_word'(rq.word);
                    n++;
                end
            end
            FN_POP: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    n--;
                    d = 32'(stack_mem[s][n]);
                end
            end
            FN_DISPLAY: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    // newest first, one reply per stored word
                    for (i = 0; i < n; i++)
                        replies_due.push_back(make_reply(ST_OK, 32'(stack_mem[s][n - 1 - i]),
                                                         1'b0, n == SLOT_DEPTH, i + 1 == n));
                    return;
                end
            end
            default: ;
        endcase
        stack_fill[s] = n;
        replies_due.push_back(make_reply(st, d, n == 0, n == SLOT_DEPTH, 1'b1));
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        failures++;
        if (failures <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    endtask

    task automatic check_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_CAP)
                $display("%0t ns: spurious result, expected none, actual status %0d data %h",
                         $time, o_status, o_data_out);
            return;
        end
        want = replies_due.pop_front();
        if (o_status !== want.status)  report_field("status", 32'(want.status), 32'(o_status));
        if (o_data_out !== want.data)  report_field("data_out", want.data, o_data_out);
        if (o_is_empty !== want.empty) report_field("is_empty", 32'(want.empty), 32'(o_is_empty));
        if (o_is_full !== want.full)   report_field("is_full", 32'(want.full), 32'(o_is_full));
        if (o_last !== want.tail)      report_field("last", 32'(want.tail), 32'(o_last));
    endtask

    // ------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------

    // Wait drawn per transaction: none inside the calm window or while the
    // receiver holds off, otherwise zero at least a third of the time
    function automatic int unsigned draw_wait();
        if (hold_left != 0 || (requests_taken >= CALM_FROM && requests_taken < CALM_TO))
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_request(input logic [2:0] func, input logic [1:0] sid,
                                 input logic [31:0] word, input bit drain);
        t_request rq;
        rq.func  = func;
        rq.sid   = sid;
        rq.word  = word;
        rq.drain = drain;
        requests_pending.push_back(rq);
    endtask

    task automatic plan_directed();
        int k;
        // refused operations, one of them also on a refused stack
        queue_request(FN_BAD_LO, 2'd1, 32'hFFFF_FFFF, 1'b0);
        queue_request(FN_BAD_MID, 2'd2, 32'h0, 1'b0);
        queue_request(FN_BAD_HI, SID_NONE, 32'h1234_5678, 1'b0);
        // refused stack
        queue_request(FN_PUSH, SID_NONE, 32'hDEAD_BEEF, 1'b0);
        queue_request(FN_POP, SID_NONE, 32'h0, 1'b0);
        // empty stacks: pop, display and both queries
        queue_request(FN_POP, 2'd1, 32'h0, 1'b0);
        queue_request(FN_DISPLAY, 2'd2, 32'h0, 1'b0);
        queue_request(FN_QEMPTY, 2'd3, 32'h0, 1'b0);
        queue_request(FN_QFULL, 2'd1, 32'h0, 1'b0);
        // extreme words
        queue_request(FN_PUSH, 2'd1, 32'h7FFF_FFFF, 1'b0);
        queue_request(FN_PUSH, 2'd1, 32'h8000_0000, 1'b0);
        queue_request(FN_PUSH, 2'd2, 32'hFFFF_FFFF, 1'b0);
        queue_request(FN_PUSH, 2'd3, 32'h0, 1'b0);
        queue_request(FN_DISPLAY, 2'd1, 32'h0, 1'b0);
        // pops must undo the matching pushes on stacks one and two
        queue_request(FN_POP, 2'd1, 32'h0, 1'b0);
        queue_request(FN_POP, 2'd2, 32'h0, 1'b0);
        // fill stack three, overflow it, then display it whole
        for (k = 1; k < SLOT_DEPTH; k++)
            queue_request(FN_PUSH, 2'd3, $urandom(), 1'b0);
        queue_request(FN_PUSH, 2'd3, $urandom(), 1'b0);
        queue_request(FN_QFULL, 2'd3, 32'h0, 1'b0);
        queue_request(FN_DISPLAY, 2'd3, 32'h0, 1'b0);
    endtask

    // Alternate push-heavy and pop-heavy phases so that stacks run full and empty
    task automatic plan_random();
        int          k;
        int unsigned roll;
        int unsigned push_w;
        int unsigned pop_w;
        logic [2:0]  func;
        logic [1:0]  sid;
        logic [1:0]  favoured;
        logic [31:0] word;
        bit          filling;
        filling  = 1'b0;
        favoured = 2'd1;
        push_w   = 15;
        pop_w    = 55;
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 30 == 0) begin
                filling  = !filling;
                favoured = 2'($urandom_range(1, 3));
                push_w   = filling ? 55 : 15;
                pop_w    = filling ? 15 : 55;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
                func = 3'($urandom_range(FN_BAD_LO, FN_BAD_HI));
            else if (roll < 5 + push_w)
                func = FN_PUSH;
            else if (roll < 5 + push_w + pop_w)
                func = FN_POP;
            else if (roll < 81)
                func = FN_QEMPTY;
            else if (roll < 87)
                func = FN_QFULL;
            else
                func = FN_DISPLAY;
            if ($urandom_range(0, 19) == 0)
                sid = SID_NONE;
            else if ($urandom_range(0, 1) == 0)
                sid = favoured;
            else
                sid = 2'($urandom_range(1, 3));
            case ($urandom_range(0, 19))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0;
                3:       word = 32'hFFFF_FFFF;
                default: word = $urandom();
            endcase
            queue_request(func, sid, word, k == RANDOM_REQUESTS / 2 || k == RANDOM_REQUESTS - 20);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            send_fire  = i_in_valid && !o_in_stall;
            send_offer = i_in_valid && !send_fire;  // hold a stalled transaction unchanged
            if (send_fire) begin
                predict_replies(active_req);
                requests_taken++;
                send_gap = draw_wait();
            end
            if (!send_offer) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (requests_pending.size() != 0 &&
                             !(requests_pending[0].drain && replies_due.size() != 0)) begin
                    // advance to the next transaction
                    active_req  = requests_pending.pop_front();
                    i_func      <= active_req.func;
                    i_stack_id  <= active_req.sid;
                    i_push_data <= active_req.word;
                    send_offer  = 1'b1;
                end
            end
            i_in_valid <= send_offer;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            reply_taken = o_out_valid && !i_out_stall;
            if (reply_taken)
                check_reply();
            // once, hold off long enough for the block to fill and stall its input
            if (!hold_done && requests_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (reply_taken)
                    recv_wait = draw_wait();
                if (recv_wait != 0) begin
                    recv_wait--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run if no transaction moves for too long
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, run the plan, drain, settle, judge
    // ------------------------------------------------------------------

    initial begin
        for (int s = 0; s < NUM_STACKS; s++)
            stack_fill[s] = 0;
        plan_directed();
        plan_random();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (requests_pending.size() != 0 || i_in_valid || replies_due.size() != 0)
            @(posedge i_clk);
        // let any stray results surface before judging
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $display("%0t ns: %0d results never arrived, expected status %0d data %h",
                     $time, replies_due.size(), replies_due[0].status, replies_due[0].data);
            failures += replies_due.size();
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
